// File: sv/pkwa_pkg.sv
`timescale 1ns / 1ps
// Package with the request and result types, status codes and residue tables.
package pkwa_pkg;

  localparam int TYPE_W   = 8;
  localparam int FRAME_W  = 8;
  localparam int WEIGHT_W = 32;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;

  localparam int FIELD_SPAN = 1 << TYPE_W;

  localparam int CAPACITY_DEF = 1024;
  localparam int FRAMES_DEF   = 256;
  localparam int TYPES_DEF    = 256;

  localparam logic [STATUS_W-1:0] ST_ACCUM   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_APPEND  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd3;

  localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef struct packed {
    logic [TYPE_W-1:0]          type_a;
    logic [TYPE_W-1:0]          type_b;
    logic [FRAME_W-1:0]         frame;
    logic signed [WEIGHT_W-1:0] weight;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]          slot;
    logic [STATUS_W-1:0]        status;
    logic signed [WEIGHT_W-1:0] cell_value;
  } out_t;

  typedef logic [FIELD_SPAN-1:0][TYPE_W-1:0] mod_tab_t;

  // Builds the table of v mod m for every 8-bit v by counting up and wrapping.
  function automatic mod_tab_t build_mod_tab(int unsigned m);
    mod_tab_t    tab;
    int unsigned r;
    r = 0;
    for (int i = 0; i < FIELD_SPAN; i++) begin
      tab[i] = TYPE_W'(r);
      if (r + 1 == m) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return tab;
  endfunction

endpackage

// File: sv/pkwa_sat_add.sv
`timescale 1ns / 1ps
// Saturating adder for signed Q16.16 cell values.
module pkwa_sat_add (
  input  logic signed [pkwa_pkg::WEIGHT_W-1:0] a_i,
  input  logic signed [pkwa_pkg::WEIGHT_W-1:0] b_i,
  output logic signed [pkwa_pkg::WEIGHT_W-1:0] sum_o
);
  import pkwa_pkg::*;

  logic signed [WEIGHT_W:0] sum_wide;

  assign sum_wide = {a_i[WEIGHT_W-1], a_i} + {b_i[WEIGHT_W-1], b_i};

  always_comb begin
    if (sum_wide[WEIGHT_W] != sum_wide[WEIGHT_W-1]) begin
      sum_o = sum_wide[WEIGHT_W] ? W_MIN : W_MAX;
    end else begin
      sum_o = sum_wide[WEIGHT_W-1:0];
    end
  end

endmodule

// File: sv/pair_keyed_weight_accumulator_unit.sv
`timescale 1ns / 1ps
// Top level of the pair-keyed weight accumulator with its sequencer and stores.
// A matching request compares the stored pairs in order from entry 0, then reads and writes back its cell.
// An append compares every stored pair, then clears its row of cells and writes the weight into its frame;
// a refused request compares every stored pair; the receiver cannot stall the result.
// A new request is accepted in the result strobe cycle, so one request runs at a time.
// Reset clears the entry count and the sequencer; each append clears its own cells.
module pair_keyed_weight_accumulator_unit #(
  parameter int CAPACITY = pkwa_pkg::CAPACITY_DEF,
  parameter int FRAMES   = pkwa_pkg::FRAMES_DEF,
  parameter int TYPES    = pkwa_pkg::TYPES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pkwa_pkg::in_t  in_item,
  output logic           out_valid,
  output pkwa_pkg::out_t out_item
);
  import pkwa_pkg::*;

  localparam int FR_EFF   = (FRAMES < FIELD_SPAN) ? FRAMES : FIELD_SPAN;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WA_DEPTH = CAPACITY * FR_EFF;
  localparam int WA_W     = (WA_DEPTH > 1) ? $clog2(WA_DEPTH) : 1;
  localparam int FC_W     = (FR_EFF > 1) ? $clog2(FR_EFF) : 1;

  localparam mod_tab_t TYPE_TAB  = build_mod_tab(TYPES);
  localparam mod_tab_t FRAME_TAB = build_mod_tab(FRAMES);

  localparam logic [WA_W-1:0]  FR_EFF_W = WA_W'(FR_EFF);
  localparam logic [FC_W-1:0]  FR_LAST  = FC_W'(FR_EFF - 1);
  localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_RMW_RD = 3'd3;
  localparam logic [2:0] S_RMW_WR = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [TYPE_W-1:0]          a_r, a_nxt;
  logic [TYPE_W-1:0]          b_r, b_nxt;
  logic [FRAME_W-1:0]         frame_r, frame_nxt;
  logic signed [WEIGHT_W-1:0] w_r, w_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           iss_r, iss_nxt;
  logic                       cmpv_r, cmpv_nxt;
  logic [IDX_W-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]           slot_r, slot_nxt;
  logic [WA_W-1:0]            addr_r, addr_nxt;
  logic [FC_W-1:0]            clr_r, clr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_t                       out_item_r, out_item_nxt;

  logic [2*TYPE_W-1:0]        pmem [CAPACITY];
  logic [2*TYPE_W-1:0]        pm_q_r;
  logic                       pm_we;
  logic [IDX_W-1:0]           pm_addr;

  logic [WEIGHT_W-1:0]        wmem [WA_DEPTH];
  logic [WEIGHT_W-1:0]        wm_q_r;
  logic                       wm_we;
  logic [WEIGHT_W-1:0]        wm_wdata;

  logic [IDX_W-1:0]           count_idx;
  logic                       hit;
  logic [IDX_W-1:0]           mul_src;
  logic [WA_W-1:0]            row_base;
  logic signed [WEIGHT_W-1:0] sum;

  pkwa_sat_add u_sat_add (
    .a_i   (wm_q_r),
    .b_i   (w_r),
    .sum_o (sum)
  );

  assign count_idx = count_r[IDX_W-1:0];
  assign hit = cmpv_r &&
               ((a_r == pm_q_r[2*TYPE_W-1:TYPE_W] && b_r == pm_q_r[TYPE_W-1:0]) ||
                (b_r == pm_q_r[2*TYPE_W-1:TYPE_W] && a_r == pm_q_r[TYPE_W-1:0]));
  assign mul_src  = hit ? cmp_idx_r : count_idx;
  assign row_base = WA_W'(mul_src) * FR_EFF_W;
  assign pm_addr  = pm_we ? count_idx : iss_r[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    frame_nxt     = frame_r;
    w_nxt         = w_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    cmpv_nxt      = cmpv_r;
    cmp_idx_nxt   = cmp_idx_r;
    slot_nxt      = slot_r;
    addr_nxt      = addr_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pm_we         = 1'b0;
    wm_we         = 1'b0;
    wm_wdata      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          a_nxt     = TYPE_TAB[in_item.type_a];
          b_nxt     = TYPE_TAB[in_item.type_b];
          frame_nxt = FRAME_TAB[in_item.frame];
          w_nxt     = in_item.weight;
          iss_nxt   = '0;
          cmpv_nxt  = 1'b0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          cmpv_nxt  = 1'b0;
          slot_nxt  = cmp_idx_r;
          addr_nxt  = row_base + WA_W'(frame_r);
          state_nxt = S_RMW_RD;
        end else if (iss_r < count_r) begin
          cmpv_nxt    = 1'b1;
          cmp_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + 1'b1;
        end else if (cmpv_r) begin
          cmpv_nxt = 1'b0;
        end else if (count_r == CAP_C) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.slot       = '0;
          out_item_nxt.status     = ST_REFUSED;
          out_item_nxt.cell_value = '0;
          state_nxt               = S_IDLE;
        end else begin
          pm_we     = 1'b1;
          slot_nxt  = count_idx;
          addr_nxt  = row_base;
          clr_nxt   = '0;
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        wm_we    = 1'b1;
        wm_wdata = (FRAME_W'(clr_r) == frame_r) ? w_r : '0;
        if (clr_r == FR_LAST) begin
          count_nxt               = count_r + 1'b1;
          out_valid_nxt           = 1'b1;
          out_item_nxt.slot       = SLOT_W'(slot_r);
          out_item_nxt.status     = (count_r + 1'b1 == CAP_C) ? ST_FULL : ST_APPEND;
          out_item_nxt.cell_value = w_r;
          state_nxt               = S_IDLE;
        end else begin
          clr_nxt  = clr_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_RMW_RD: begin
        state_nxt = S_RMW_WR;
      end
      S_RMW_WR: begin
        wm_we                   = 1'b1;
        wm_wdata                = sum;
        out_valid_nxt           = 1'b1;
        out_item_nxt.slot       = SLOT_W'(slot_r);
        out_item_nxt.status     = ST_ACCUM;
        out_item_nxt.cell_value = sum;
        state_nxt               = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmpv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmpv_r      <= cmpv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    frame_r    <= frame_nxt;
    w_r        <= w_nxt;
    iss_r      <= iss_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    slot_r     <= slot_nxt;
    addr_r     <= addr_nxt;
    clr_r      <= clr_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_addr] <= {a_r, b_r};
    end
    pm_q_r <= pmem[pm_addr];
  end

  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[addr_r] <= wm_wdata;
    end
    wm_q_r <= wmem[addr_r];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: sv/pkwa_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the accumulator and the bind that attaches it.
module pkwa_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input pkwa_pkg::out_t out_item
);
  import pkwa_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted request did not make the block busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("request finished without a result");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_REFUSED |->
      out_item.slot == '0 && out_item.cell_value == '0)
    else $error("refused request reported a nonzero slot or value");

endmodule

bind pair_keyed_weight_accumulator_unit pkwa_chk u_pkwa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the pair-keyed weight accumulator: directed and random requests.
module tb_top;
  import pkwa_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int NFRAMES      = FRAMES_DEF;
  localparam int NTYPES       = TYPES_DEF;
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int DRAIN_CYCLES = CAP + 300;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;

  out_t        expected_results[$];
  out_t        oldest_expected;
  logic [7:0]  known_first[CAP];
  logic [7:0]  known_second[CAP];
  int          cell_mem[CAP * NFRAMES];
  int          stored_pairs = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          steady = 1'b0;

  pair_keyed_weight_accumulator_unit #(
    .CAPACITY(CAP),
    .FRAMES(NFRAMES),
    .TYPES(NTYPES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int find_pair(int a, int b);
    for (int i = 0; i < stored_pairs; i++) begin
      if ((known_first[i] == a && known_second[i] == b) ||
          (known_first[i] == b && known_second[i] == a)) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Updates the local copy of the tables for one request and returns its result.
  function automatic out_t apply_request(in_t req);
    out_t   res;
    int     a;
    int     b;
    int     f;
    int     idx;
    longint sum;
    a   = int'(req.type_a) % NTYPES;
    b   = int'(req.type_b) % NTYPES;
    f   = int'(req.frame) % NFRAMES;
    idx = find_pair(a, b);
    if (idx >= 0) begin
      sum = longint'(cell_mem[f * CAP + idx]) + longint'(req.weight);
      if (sum > longint'(W_MAX)) sum = longint'(W_MAX);
      if (sum < longint'(W_MIN)) sum = longint'(W_MIN);
      cell_mem[f * CAP + idx] = int'(sum);
      res.slot       = SLOT_W'(idx);
      res.status     = ST_ACCUM;
      res.cell_value = WEIGHT_W'(sum);
    end else if (stored_pairs >= CAP) begin
      res.slot       = '0;
      res.status     = ST_REFUSED;
      res.cell_value = '0;
    end else begin
      known_first[stored_pairs]               = TYPE_W'(a);
      known_second[stored_pairs]              = TYPE_W'(b);
      cell_mem[f * CAP + stored_pairs]        = int'(req.weight);
      res.slot                                = SLOT_W'(stored_pairs);
      stored_pairs                            = stored_pairs + 1;
      res.status     = (stored_pairs >= CAP) ? ST_FULL : ST_APPEND;
      res.cell_value = req.weight;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] random_weight();
    case ($urandom_range(3))
      0: return $urandom;
      1: return W_MAX - $urandom_range(255);
      2: return W_MIN + $urandom_range(255);
      default: return $signed(32'($urandom_range(131072))) - 65536;
    endcase
  endfunction

  function automatic logic [7:0] random_frame();
    if ($urandom_range(1)) return 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_request(input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] f, input logic signed [31:0] w);
    in_t req;
    req.type_a = a;
    req.type_b = b;
    req.frame  = f;
    req.weight = w;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    in_item <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(apply_request(req));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: slot %0d status %0d value %0d",
                 $time, out_item.slot, out_item.status, out_item.cell_value);
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_item.slot !== oldest_expected.slot) begin
          mismatches++;
          $display("%0t: slot expected %0d got %0d", $time, oldest_expected.slot,
                   out_item.slot);
        end
        if (out_item.status !== oldest_expected.status) begin
          mismatches++;
          $display("%0t: status expected %0d got %0d", $time, oldest_expected.status,
                   out_item.status);
        end
        if (out_item.cell_value !== oldest_expected.cell_value) begin
          mismatches++;
          $display("%0t: cell_value expected %0d got %0d", $time,
                   oldest_expected.cell_value, out_item.cell_value);
        end
      end
    end
  end

  task automatic test_pair_lookup();
    send_request(8'd0, 8'd0, 8'd0, W_MAX);
    send_request(8'd255, 8'd255, 8'd255, W_MIN);
    send_request(8'd1, 8'd2, 8'd7, 32'sh0001_0000);
    send_request(8'd2, 8'd1, 8'd7, 32'sh0002_8000);
    send_request(8'd2, 8'd1, 8'd8, -32'sd5);
    send_request(8'hAA, 8'h55, 8'h55, 32'sh5555_5555);
    send_request(8'h55, 8'hAA, 8'hAA, 32'shAAAA_AAAA);
    send_request(8'd0, 8'd255, 8'd128, 32'sd0);
    send_request(8'd255, 8'd0, 8'd128, -32'sd1);
    send_request(8'd0, 8'd0, 8'd255, 32'sd1);
  endtask

  task automatic test_saturation();
    send_request(8'd0, 8'd0, 8'd0, 32'sd1);
    send_request(8'd0, 8'd0, 8'd0, W_MAX);
    send_request(8'd0, 8'd0, 8'd0, -32'sd1);
    send_request(8'd255, 8'd255, 8'd255, -32'sd1);
    send_request(8'd255, 8'd255, 8'd255, W_MIN);
    send_request(8'd255, 8'd255, 8'd255, W_MAX);
    send_request(8'd1, 8'd2, 8'd7, W_MAX);
    send_request(8'd2, 8'd1, 8'd7, W_MIN);
  endtask

  // Mostly requests on stored pairs, so that cells build up and saturate; some new pairs.
  task automatic test_random_mix(input int count);
    int         idx;
    int         pick;
    logic [7:0] a;
    logic [7:0] b;
    for (int n = 0; n < count; n++) begin
      steady = (n >= count / 3) && (n < count / 2);
      pick = $urandom_range(99);
      if (pick < 75) begin
        idx = $urandom_range(stored_pairs - 1);
        a   = known_first[idx];
        b   = known_second[idx];
        if ($urandom_range(1)) begin
          a = known_second[idx];
          b = known_first[idx];
        end
      end else begin
        a = 8'($urandom_range(255));
        b = (pick < 80) ? a : 8'($urandom_range(255));
      end
      send_request(a, b, random_frame(), random_weight());
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_pair_lookup();
    test_saturation();
    test_random_mix(562);

    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
